[hw/rtl/akat_pkg.sv]
// ----------------------------------------------------------------------------
// akat_pkg: shared definitions for the analog key actuation tracker
// Sizes, reset values, codes and the per-key record kept in memory.
// ----------------------------------------------------------------------------
`default_nettype none

package akat_pkg;

    localparam int KEYS      = 2;
    localparam int TAPS      = 4;   // window depth, a power of two
    localparam int SMP_W     = 12;
    localparam int PCT_W     = 7;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;

    localparam int KEY_W     = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int SLOT_W    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int SUM_W     = SMP_W + SLOT_W;
    localparam int WIN_AW    = KEY_W + SLOT_W;
    localparam int WIN_DEPTH = (1 << KEY_W) * TAPS;
    localparam int NUM_W     = SMP_W + PCT_W;
    localparam int CNT_W     = $clog2(NUM_W);

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;

    localparam int                 PCT_SCALE = 100;
    localparam logic [PCT_W-1:0]   PCT_FULL  = PCT_W'(PCT_SCALE);

    localparam logic [PCT_W-1:0]   RST_PRESS_LEVEL   = PCT_W'(75);
    localparam logic [PCT_W-1:0]   RST_RELEASE_LEVEL = PCT_W'(60);
    localparam logic [SMP_W-1:0]   RST_START_MIN     = SMP_W'(2300);
    localparam logic [SMP_W-1:0]   RST_START_MAX     = SMP_W'(2500);

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2
    } event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESS_LEVEL   = 2'd0,
        REG_RELEASE_LEVEL = 2'd1,
        REG_START_MIN     = 2'd2,
        REG_START_MAX     = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic              down;
        logic [SMP_W-1:0]  max_v;
        logic [SMP_W-1:0]  min_v;
        logic [SLOT_W-1:0] slot;
        logic [SUM_W-1:0]  sum;
    } key_rec_t;

endpackage

`default_nettype wire

[hw/rtl/akat_ram.sv]
// ----------------------------------------------------------------------------
// akat_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module akat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                                      aclk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/analog_key_actuation_tracker.sv]
// ----------------------------------------------------------------------------
// analog_key_actuation_tracker: Hall-effect key travel and press tracking
// Moving average, min/max calibration, percent scaling and press/release
// hysteresis for a set of analog keys, one sample per transfer.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Signals                       Contents
//  s_       in         s_tvalid s_tready s_tdata     sample in, key index in tuser
//  m_       out        m_tvalid m_tready m_tdata     average, percent, state, event
//  cfg_     in         cfg_we cfg_index cfg_wdata    hysteresis levels, start range
//
//  Each sample goes through the reads, the update, the scaling multiply and
//  the bit-serial percent divider before the block can take the next one.
//  A result sits in the output register until it is taken; the next sample
//  is accepted meanwhile, and the block waits at the end of that sample only
//  if the previous result is still unclaimed.
//  Reset is synchronous and active low. No clearing pass is needed: a
//  per-key primed flag decides whether the key record in memory is used.
//
`default_nettype none

module analog_key_actuation_tracker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input stream.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [akat_pkg::S_TDATA_W-1:0]    s_tdata,  // [11:0] sample
    input  wire logic [akat_pkg::S_TUSER_W-1:0]    s_tuser,  // [0] key_index
    // Result stream.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [11:0] averaged, [18:12] percent, [19] pressed, [21:20] event_res
    output logic      [akat_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic      [akat_pkg::M_TUSER_W-1:0]    m_tuser,  // [0] key_out
    // Configuration writes.
    input  wire logic                              cfg_we,
    input  wire logic [akat_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [akat_pkg::CFG_W-1:0]        cfg_wdata
);

    import akat_pkg::*;

    // The sequencer walks one sample through memory reads, the update, the
    // scaling multiply, the divider and the write back.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SLOT,
        ST_CALC,
        ST_SCALE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [PCT_W-1:0] press_level_reg;
    logic [PCT_W-1:0] release_level_reg;
    logic [SMP_W-1:0] start_min_reg;
    logic [SMP_W-1:0] start_max_reg;

    // A key's record in memory is meaningful only once the key is primed.
    logic [KEYS-1:0]   primed_reg;

    // Item and datapath registers.
    logic [KEY_W-1:0]  key_reg;
    logic [SMP_W-1:0]  sample_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SMP_W-1:0]  avg_reg;
    logic [SMP_W-1:0]  min_reg;
    logic [SMP_W-1:0]  max_reg;
    logic              range_ok_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [SMP_W-1:0]  rem_reg;
    logic [SMP_W-1:0]  den_reg;
    logic [CNT_W-1:0]  cnt_reg;

    // Window fill sweep for the first sample of a key.
    logic              fill_act_reg;
    logic [SLOT_W-1:0] fill_cnt_reg;

    // Output register.
    logic              m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    // ------------------------------------------------------------------
    // Handshake and memories
    // ------------------------------------------------------------------
    logic             s_acc;
    logic [KEY_W-1:0] key_in;
    logic             out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // The key index is reduced to the number of keys present.
    assign key_in = (KEYS > 1) ? KEY_W'(s_tuser[0]) : '0;

    logic [$bits(key_rec_t)-1:0] key_rdata;
    key_rec_t                    key_rd;
    key_rec_t                    key_wr;
    logic                        key_we;

    assign key_rd = key_rec_t'(key_rdata);

    akat_ram #(
        .WIDTH ($bits(key_rec_t)),
        .DEPTH (KEYS)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (key_reg),
        .wdata (key_wr),
        .re    (s_acc),
        .raddr (key_in),
        .rdata (key_rdata)
    );

    logic              is_prime;
    logic [SLOT_W-1:0] cur_slot;
    logic              win_we;
    logic [WIN_AW-1:0] win_waddr;
    logic [SMP_W-1:0]  win_rdata;

    assign is_prime = !primed_reg[key_reg];
    assign cur_slot = is_prime ? '0 : key_rd.slot;

    // Fill sweep and the single-entry update never fall in the same cycle.
    assign win_we    = fill_act_reg || ((state_reg == ST_CALC) && !is_prime);
    assign win_waddr = fill_act_reg ? {key_reg, fill_cnt_reg} : {key_reg, cur_slot};

    akat_ram #(
        .WIDTH (SMP_W),
        .DEPTH (WIN_DEPTH)
    ) u_win_ram (
        .aclk  (aclk),
        .we    (win_we),
        .waddr (win_waddr),
        .wdata (sample_reg),
        .re    (state_reg == ST_SLOT),
        .raddr ({key_reg, cur_slot}),
        .rdata (win_rdata)
    );

    // ------------------------------------------------------------------
    // Window and calibration update (ST_CALC)
    // ------------------------------------------------------------------
    logic [SMP_W-1:0] old_tap;
    logic [SUM_W-1:0] base_sum;
    logic [SUM_W-1:0] new_sum;
    logic [SMP_W-1:0] avg_c;
    logic [SMP_W-1:0] min0, max0, min1, max1;

    always_comb begin
        // A fresh key behaves as if every tap already holds this sample.
        old_tap  = is_prime ? sample_reg : win_rdata;
        base_sum = is_prime ? {sample_reg, {SLOT_W{1'b0}}} : key_rd.sum;
        new_sum  = base_sum - SUM_W'(old_tap) + SUM_W'(sample_reg);
        avg_c    = new_sum[SUM_W-1 -: SMP_W];
        min0     = is_prime ? start_min_reg : key_rd.min_v;
        if (is_prime) begin
            max0 = (sample_reg > start_max_reg) ? sample_reg : start_max_reg;
        end else begin
            max0 = key_rd.max_v;
        end
        min1 = min0;
        max1 = max0;
        priority if (avg_c < min0) begin
            min1 = avg_c;
        end else if (avg_c > max0) begin
            max1 = avg_c;
        end
    end

    // ------------------------------------------------------------------
    // Scaling (ST_SCALE): the average never sits below the minimum here.
    // ------------------------------------------------------------------
    logic [NUM_W-1:0] num_c;

    assign num_c = NUM_W'(avg_reg - min_reg) * NUM_W'(PCT_SCALE);

    // ------------------------------------------------------------------
    // One restoring division step per cycle (ST_DIV).
    // ------------------------------------------------------------------
    logic [SMP_W:0]   trial;
    logic             trial_ge;
    logic [SMP_W:0]   trial_diff;

    assign trial      = {rem_reg, quo_reg[NUM_W-1]};
    assign trial_ge   = (trial >= {1'b0, den_reg});
    assign trial_diff = trial - {1'b0, den_reg};

    // ------------------------------------------------------------------
    // Percent, hysteresis and write back (ST_DONE)
    // ------------------------------------------------------------------
    logic [PCT_W-1:0]  pct;
    logic              down_old;
    logic              down_new;
    event_t            ev;
    logic [SLOT_W-1:0] slot_inc;
    logic              done_go;

    always_comb begin
        if (!range_ok_reg) begin
            pct = '0;
        end else if (quo_reg > NUM_W'(PCT_SCALE)) begin
            pct = PCT_FULL;
        end else begin
            pct = quo_reg[PCT_W-1:0];
        end
        down_old = is_prime ? 1'b0 : key_rd.down;
        down_new = down_old;
        ev       = EV_NONE;
        priority if ((pct >= press_level_reg) && !down_old) begin
            down_new = 1'b1;
            ev       = EV_PRESS;
        end else if ((pct <= release_level_reg) && down_old) begin
            down_new = 1'b0;
            ev       = EV_RELEASE;
        end
        slot_inc = (slot_reg == SLOT_W'(TAPS - 1)) ? '0 : slot_reg + 1'b1;
    end

    assign done_go = (state_reg == ST_DONE) && out_free && !fill_act_reg;
    assign key_we  = done_go;

    always_comb begin
        key_wr.down  = down_new;
        key_wr.max_v = max_reg;
        key_wr.min_v = min_reg;
        key_wr.slot  = slot_inc;
        key_wr.sum   = sum_reg;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_acc) begin
                state_next = ST_SLOT;
            end
            ST_SLOT:  state_next = ST_CALC;
            ST_CALC:  state_next = ST_SCALE;
            ST_SCALE: state_next = ST_DIV;
            ST_DIV:   if (cnt_reg == '0) begin
                state_next = ST_DONE;
            end
            ST_DONE:  if (done_go) begin
                state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            primed_reg        <= '0;
            fill_act_reg      <= 1'b0;
            fill_cnt_reg      <= '0;
            m_tvalid_reg      <= 1'b0;
            press_level_reg   <= RST_PRESS_LEVEL;
            release_level_reg <= RST_RELEASE_LEVEL;
            start_min_reg     <= RST_START_MIN;
            start_max_reg     <= RST_START_MAX;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_PRESS_LEVEL:   press_level_reg   <= cfg_wdata[PCT_W-1:0];
                    REG_RELEASE_LEVEL: release_level_reg <= cfg_wdata[PCT_W-1:0];
                    REG_START_MIN:     start_min_reg     <= cfg_wdata[SMP_W-1:0];
                    REG_START_MAX:     start_max_reg     <= cfg_wdata[SMP_W-1:0];
                    default: ;
                endcase
            end

            if (s_acc) begin
                key_reg    <= key_in;
                sample_reg <= s_tdata[SMP_W-1:0];
            end

            if (fill_act_reg) begin
                fill_cnt_reg <= fill_cnt_reg + 1'b1;
                if (fill_cnt_reg == SLOT_W'(TAPS - 1)) begin
                    fill_act_reg <= 1'b0;
                end
            end

            unique case (state_reg)
                ST_CALC: begin
                    slot_reg <= cur_slot;
                    sum_reg  <= new_sum;
                    avg_reg  <= avg_c;
                    min_reg  <= min1;
                    max_reg  <= max1;
                    if (is_prime) begin
                        fill_act_reg <= 1'b1;
                        fill_cnt_reg <= '0;
                    end
                end
                ST_SCALE: begin
                    range_ok_reg <= (max_reg > min_reg);
                    quo_reg      <= num_c;
                    rem_reg      <= '0;
                    den_reg      <= max_reg - min_reg;
                    cnt_reg      <= CNT_W'(NUM_W - 1);
                end
                ST_DIV: begin
                    rem_reg <= trial_ge ? trial_diff[SMP_W-1:0] : trial[SMP_W-1:0];
                    quo_reg <= {quo_reg[NUM_W-2:0], trial_ge};
                    cnt_reg <= cnt_reg - 1'b1;
                end
                default: ;
            endcase

            // A new result replaces one that is taken in the same cycle.
            if (done_go) begin
                primed_reg[key_reg] <= 1'b1;
                m_tvalid_reg        <= 1'b1;
                m_tdata_reg         <= M_TDATA_W'({ev, down_new, pct, avg_reg});
                m_tuser_reg         <= M_TUSER_W'(key_reg);
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

[hw/rtl/akat_checker.sv]
// ----------------------------------------------------------------------------
// akat_checker: port-level checks for the analog key actuation tracker
// Watches the streams and flags results that break the block's rules.
// ----------------------------------------------------------------------------
`default_nettype none

module akat_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [akat_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [akat_pkg::M_TUSER_W-1:0] m_tuser
);

    import akat_pkg::*;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    // One sample at a time: the input side closes right after a transfer.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second sample accepted while one is in progress");

    // An event agrees with the reported key state.
    a_event_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[21:20] == EV_NONE)
                  || (m_tdata[21:20] == EV_PRESS && m_tdata[19])
                  || (m_tdata[21:20] == EV_RELEASE && !m_tdata[19]))
        else $error("event does not match key state");

    // Percent never exceeds full travel.
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[18:12] <= PCT_FULL)
        else $error("percent above full travel");

endmodule

bind analog_key_actuation_tracker akat_checker u_akat_checker (.*);

`default_nettype wire
